### rtl/gsp_pkg.sv
// gsp_pkg: shared widths, codes and controller/datapath interface types
// for the generational slot pool. No dependencies.
package gsp_pkg;

	localparam int unsigned POOL_DEPTH_DEF   = 1024;
	localparam int unsigned VERSION_BITS_DEF = 16;

	localparam int OP_W      = 2;
	localparam int IDX_W     = 10;
	localparam int VER_W     = 16;
	localparam int STAT_W    = 2;
	localparam int SIZE_W    = 11;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 11;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_CHECK   = 2'd2,
		OP_REINIT  = 2'd3
	} op_t;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [STAT_W-1:0] ST_STALE     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd2;

	localparam logic [CFG_W-1:0] RST_INITIAL = 11'd64;
	localparam logic [CFG_W-1:0] RST_MAX     = 11'd1024;
	localparam logic [CFG_W-1:0] RST_STEP    = 11'd64;

	typedef struct packed {
		logic latch;
		logic rd_idx;
		logic rd_head;
		logic rd_next;
		logic pop;
		logic resolve;
		logic rel;
		logic exhaust;
		logic grow_setup;
		logic rebuild_setup;
		logic sweep_wr;
		logic grow_link;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic head_none;
		logic grow_ok;
		logic need_grow;
		logic init_zero;
		logic sweep_last;
	} stat_t;

endpackage

### rtl/generational_slot_pool_unit.sv
// generational_slot_pool_unit: top level of the slot pool, gsp_ctrl plus gsp_dp.
// Depends on gsp_pkg, gsp_ctrl and gsp_dp.
//
//   channel   handshake              fields
//   request   in_valid / in_ready    op, handle_index, handle_version
//   result    out_valid / out_ready  status, slot_out, version_out, pool_size
//   config    cfg_we                 cfg_index, cfg_data
//
// release and check wait on the registered read of the generation memory
// allocate does a head read, then the dependent link read of the new head, skipped when exhausted,
// and may add growth sweeps of the link memory, before the pop and after it
// reinit rewrites the first initial_size slots, one slot written per cycle
// after reset a sweep of the first min(64, POOL_DEPTH) slots builds the free list, in_ready low
// a pending result holds in the output register while the next request is taken
module generational_slot_pool_unit #(
	parameter int unsigned POOL_DEPTH   = gsp_pkg::POOL_DEPTH_DEF,
	parameter int unsigned VERSION_BITS = gsp_pkg::VERSION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gsp_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [gsp_pkg::OP_W-1:0]       op,
	input  logic [gsp_pkg::IDX_W-1:0]      handle_index,
	input  logic [gsp_pkg::VER_W-1:0]      handle_version,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [gsp_pkg::STAT_W-1:0]     status,
	output logic [gsp_pkg::IDX_W-1:0]      slot_out,
	output logic [gsp_pkg::VER_W-1:0]      version_out,
	output logic [gsp_pkg::SIZE_W-1:0]     pool_size
);
	import gsp_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	gsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	gsp_dp #(
		.POOL_DEPTH   (POOL_DEPTH),
		.VERSION_BITS (VERSION_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.handle_index   (handle_index),
		.handle_version (handle_version),
		.cmd            (cmd),
		.stat           (stat),
		.status         (status),
		.slot_out       (slot_out),
		.version_out    (version_out),
		.pool_size      (pool_size)
	);

endmodule

### rtl/gsp_ctrl.sv
// gsp_ctrl: sequencer for allocate, release, check, reinit and slot sweeps.
// Depends on gsp_pkg; drives gsp_dp through cmd_t and reads stat_t.
module gsp_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [gsp_pkg::OP_W-1:0]  op,
	output logic                      out_valid,
	input  logic                      out_ready,
	input  gsp_pkg::stat_t            stat,
	output gsp_pkg::cmd_t             cmd
);
	import gsp_pkg::*;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_ACHK,
		S_APOP,
		S_ANXT,
		S_GLNK,
		S_HCMP,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		K_INIT,
		K_REBUILD,
		K_GROW
	} kind_t;

	state_t state_q;
	kind_t  kind_q;
	logic   post_q;
	op_t    op_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					case (op_t'(op))
						OP_RELEASE, OP_CHECK: cmd.rd_idx = 1'b1;
						OP_REINIT:            cmd.rebuild_setup = 1'b1;
						default:              cmd.latch = 1'b1;
					endcase
				end
			end
			S_ACHK: begin
				if (!stat.head_none) begin
					cmd.rd_head = 1'b1;
				end else if (stat.grow_ok) begin
					cmd.grow_setup = 1'b1;
				end else begin
					cmd.exhaust = 1'b1;
				end
			end
			S_APOP: begin
				cmd.pop     = 1'b1;
				cmd.rd_next = 1'b1;
			end
			S_ANXT: begin
				cmd.grow_setup = stat.need_grow && stat.grow_ok;
			end
			S_SWEEP: cmd.sweep_wr = 1'b1;
			S_GLNK:  cmd.grow_link = 1'b1;
			S_HCMP: begin
				cmd.resolve = 1'b1;
				cmd.rel     = (op_q == OP_RELEASE);
			end
			S_FIN:   cmd.emit = !out_valid_q || out_ready;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			kind_q      <= K_INIT;
			post_q      <= 1'b0;
			op_q        <= OP_ALLOC;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= op_t'(op);
						case (op_t'(op))
							OP_ALLOC: state_q <= S_ACHK;
							OP_RELEASE, OP_CHECK: state_q <= S_HCMP;
							OP_REINIT: begin
								kind_q  <= K_REBUILD;
								state_q <= stat.init_zero ? S_FIN : S_SWEEP;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ACHK: begin
					if (!stat.head_none) begin
						state_q <= S_APOP;
					end else if (stat.grow_ok) begin
						kind_q  <= K_GROW;
						post_q  <= 1'b0;
						state_q <= S_SWEEP;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_APOP: state_q <= S_ANXT;
				S_ANXT: begin
					if (stat.need_grow && stat.grow_ok) begin
						kind_q  <= K_GROW;
						post_q  <= 1'b1;
						state_q <= S_SWEEP;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SWEEP: begin
					if (stat.sweep_last) begin
						case (kind_q)
							K_INIT:    state_q <= S_IDLE;
							K_REBUILD: state_q <= S_FIN;
							K_GROW:    state_q <= S_GLNK;
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_GLNK: state_q <= post_q ? S_FIN : S_ACHK;
				S_HCMP: state_q <= S_FIN;
				S_FIN: begin
					if (cmd.emit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/gsp_dp.sv
// gsp_dp: link and generation memories, free-list head, sizes, config and result registers.
// Depends on gsp_pkg; sequenced by gsp_ctrl through cmd_t.
module gsp_dp #(
	parameter int unsigned POOL_DEPTH   = gsp_pkg::POOL_DEPTH_DEF,
	parameter int unsigned VERSION_BITS = gsp_pkg::VERSION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gsp_pkg::CFG_W-1:0]      cfg_data,
	input  logic [gsp_pkg::IDX_W-1:0]      handle_index,
	input  logic [gsp_pkg::VER_W-1:0]      handle_version,
	input  gsp_pkg::cmd_t                  cmd,
	output gsp_pkg::stat_t                 stat,
	output logic [gsp_pkg::STAT_W-1:0]     status,
	output logic [gsp_pkg::IDX_W-1:0]      slot_out,
	output logic [gsp_pkg::VER_W-1:0]      version_out,
	output logic [gsp_pkg::SIZE_W-1:0]     pool_size
);
	import gsp_pkg::*;

	localparam int AW  = $clog2(POOL_DEPTH);
	localparam int LW  = AW + 1;
	localparam int SZW = (LW > CFG_W) ? LW : CFG_W;
	localparam int VB  = VERSION_BITS;
	localparam int CW  = (VB > VER_W) ? VB : VER_W;

	localparam logic [LW-1:0]  NONE     = LW'(POOL_DEPTH);
	localparam logic [SZW-1:0] DEPTH_SZ = SZW'(POOL_DEPTH);
	localparam logic [VB-1:0]  VMAX     = {VB{1'b1}};
	localparam logic [SZW-1:0] RST_ACT  =
		(SZW'(RST_INITIAL) > DEPTH_SZ) ? DEPTH_SZ : SZW'(RST_INITIAL);

	typedef struct packed {
		logic          freed;
		logic [VB-1:0] mag;
	} gen_t;

	logic [LW-1:0] link_mem [0:POOL_DEPTH-1];
	gen_t          gen_mem  [0:POOL_DEPTH-1];

	logic [LW-1:0] link_rd_q;
	gen_t          gen_rd_q;

	logic [CFG_W-1:0] init_q, max_q, step_q;
	logic [SZW-1:0]   active_q, ptr_q, to_q, from_q;
	logic [LW-1:0]    head_q;

	logic [IDX_W-1:0]  idx_q;
	logic [VER_W-1:0]  ver_q;
	logic [STAT_W-1:0] res_status_q, status_q;
	logic [IDX_W-1:0]  res_slot_q, slot_q;
	logic [VER_W-1:0]  res_ver_q, ver_out_q;
	logic [SIZE_W-1:0] pool_q;

	logic [SZW-1:0] init_sz, init_clamp, max_sz, lim, grow_nsz, ptr_nx;
	logic [SZW:0]   grow_sum;
	logic           head_none, link_none, handle_ok, rel_go;
	logic [VB-1:0]  new_mag;

	logic          link_we, link_re, gen_we, gen_re;
	logic [AW-1:0] link_wa, link_ra, gen_wa, gen_ra;
	logic [LW-1:0] link_wd;
	gen_t          gen_wd;

	assign init_sz    = SZW'(init_q);
	assign init_clamp = (init_sz > DEPTH_SZ) ? DEPTH_SZ : init_sz;
	assign max_sz     = SZW'(max_q);
	assign lim        = (max_sz > DEPTH_SZ) ? DEPTH_SZ : max_sz;
	assign grow_sum   = {1'b0, active_q} + (SZW + 1)'(step_q);
	assign grow_nsz   = (grow_sum > {1'b0, lim}) ? lim : grow_sum[SZW-1:0];
	assign ptr_nx     = ptr_q + SZW'(1);
	assign head_none  = (head_q == NONE);
	assign link_none  = (link_rd_q == NONE);
	assign new_mag    = (gen_rd_q.mag == VMAX) ? VB'(1) : gen_rd_q.mag + VB'(1);
	assign handle_ok  = (SZW'(idx_q) < active_q) && (ver_q != '0) && !gen_rd_q.freed
		&& (CW'(gen_rd_q.mag) == CW'(ver_q));
	assign rel_go     = cmd.resolve && cmd.rel && handle_ok;

	assign stat.head_none  = head_none;
	assign stat.grow_ok    = (active_q < lim) && (step_q != '0);
	assign stat.need_grow  = head_none || link_none;
	assign stat.init_zero  = (init_clamp == '0);
	assign stat.sweep_last = (ptr_nx >= to_q);

	always_comb begin
		link_we = 1'b0;
		link_wa = '0;
		link_wd = '0;
		if (cmd.sweep_wr) begin
			link_we = 1'b1;
			link_wa = AW'(ptr_q);
			link_wd = (ptr_nx < to_q) ? LW'(ptr_nx) : NONE;
		end else if (cmd.grow_link && !head_none) begin
			link_we = 1'b1;
			link_wa = head_q[AW-1:0];
			link_wd = LW'(from_q);
		end else if (rel_go) begin
			link_we = 1'b1;
			link_wa = AW'(idx_q);
			link_wd = head_q;
		end
	end

	always_comb begin
		gen_we = 1'b0;
		gen_wa = '0;
		gen_wd = '0;
		if (cmd.sweep_wr) begin
			gen_we = 1'b1;
			gen_wa = AW'(ptr_q);
		end else if (cmd.pop) begin
			gen_we       = 1'b1;
			gen_wa       = head_q[AW-1:0];
			gen_wd.mag   = new_mag;
		end else if (rel_go) begin
			gen_we       = 1'b1;
			gen_wa       = AW'(idx_q);
			gen_wd.freed = 1'b1;
			gen_wd.mag   = gen_rd_q.mag;
		end
	end

	assign link_re = cmd.rd_head || (cmd.rd_next && !link_none);
	assign link_ra = cmd.rd_head ? head_q[AW-1:0] : link_rd_q[AW-1:0];
	assign gen_re  = cmd.rd_head || (cmd.rd_idx && (SZW'(handle_index) < DEPTH_SZ));
	assign gen_ra  = cmd.rd_head ? head_q[AW-1:0] : AW'(handle_index);

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (link_re) begin
			link_rd_q <= link_mem[link_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (gen_we) begin
			gen_mem[gen_wa] <= gen_wd;
		end
		if (gen_re) begin
			gen_rd_q <= gen_mem[gen_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q   <= RST_INITIAL;
			max_q    <= RST_MAX;
			step_q   <= RST_STEP;
			active_q <= RST_ACT;
			head_q   <= '0;
			ptr_q    <= '0;
			to_q     <= RST_ACT;
			from_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_INITIAL: init_q <= cfg_data;
					CFG_MAX:     max_q  <= cfg_data;
					CFG_STEP:    step_q <= cfg_data;
					default:     init_q <= init_q;
				endcase
			end
			if (cmd.rebuild_setup) begin
				active_q <= init_clamp;
				head_q   <= (init_clamp != '0) ? '0 : NONE;
				ptr_q    <= '0;
				to_q     <= init_clamp;
			end
			if (cmd.grow_setup) begin
				active_q <= grow_nsz;
				from_q   <= active_q;
				ptr_q    <= active_q;
				to_q     <= grow_nsz;
			end
			if (cmd.sweep_wr) begin
				ptr_q <= ptr_nx;
			end
			if (cmd.grow_link && head_none) begin
				head_q <= LW'(from_q);
			end
			if (cmd.pop) begin
				head_q <= link_rd_q;
			end
			if (rel_go) begin
				head_q <= LW'(idx_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			idx_q <= handle_index;
			ver_q <= handle_version;
		end
		if (cmd.rebuild_setup || cmd.exhaust) begin
			res_status_q <= cmd.exhaust ? ST_EXHAUSTED : ST_OK;
			res_slot_q   <= '0;
			res_ver_q    <= '0;
		end
		if (cmd.pop) begin
			res_status_q <= ST_OK;
			res_slot_q   <= IDX_W'(head_q);
			res_ver_q    <= VER_W'(new_mag);
		end
		if (cmd.resolve) begin
			res_status_q <= handle_ok ? ST_OK : ST_STALE;
			res_slot_q   <= idx_q;
			res_ver_q    <= '0;
		end
		if (cmd.emit) begin
			status_q  <= res_status_q;
			slot_q    <= res_slot_q;
			ver_out_q <= res_ver_q;
			pool_q    <= SIZE_W'(active_q);
		end
	end

	assign status      = status_q;
	assign slot_out    = slot_q;
	assign version_out = ver_out_q;
	assign pool_size   = pool_q;

endmodule

### rtl/gsp_checker.sv
// gsp_checker: port-level assertions for generational_slot_pool_unit, with its bind.
// Depends on gsp_pkg.
module gsp_checker #(
	parameter int unsigned POOL_DEPTH = gsp_pkg::POOL_DEPTH_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [gsp_pkg::STAT_W-1:0]  status,
	input logic [gsp_pkg::IDX_W-1:0]   slot_out,
	input logic [gsp_pkg::VER_W-1:0]   version_out,
	input logic [gsp_pkg::SIZE_W-1:0]  pool_size
);
	import gsp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({status, slot_out, version_out, pool_size}))
		else $error("result changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_EXHAUSTED || status == ST_STALE)
		else $error("illegal status code");

	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> version_out == '0
			&& (status != ST_EXHAUSTED || slot_out == '0))
		else $error("failed request carries a handle");

	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(pool_size) <= POOL_DEPTH)
		else $error("pool size above depth");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken in back-to-back cycles");

endmodule

bind generational_slot_pool_unit gsp_checker #(.POOL_DEPTH(POOL_DEPTH)) u_gsp_checker (.*);

### test/gsp_pool_checker.sv
// gsp_pool_checker: watches the config port and the request and result channels of the
// generational slot pool, predicts each result and compares it. Depends on gsp_pkg.
module gsp_pool_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gsp_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [gsp_pkg::OP_W-1:0]      op,
	input  logic [gsp_pkg::IDX_W-1:0]     handle_index,
	input  logic [gsp_pkg::VER_W-1:0]     handle_version,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [gsp_pkg::STAT_W-1:0]    status,
	input  logic [gsp_pkg::IDX_W-1:0]     slot_out,
	input  logic [gsp_pkg::VER_W-1:0]     version_out,
	input  logic [gsp_pkg::SIZE_W-1:0]    pool_size,
	output int                            fail_count,
	output int                            pending,
	output int                            n_results,
	output int                            n_exhausted,
	output int                            n_stale,
	output int                            n_grows
);
	import gsp_pkg::*;

	localparam int DEPTH = POOL_DEPTH_DEF;
	localparam logic [SIZE_W-1:0] LINK_END = SIZE_W'(DEPTH);
	localparam logic [VER_W-1:0] VER_TOP = {VER_W{1'b1}};

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  slot;
		logic [VER_W-1:0]  version;
		logic [SIZE_W-1:0] size;
	} pool_result_t;

	logic [CFG_W-1:0]  cfg_initial, cfg_max, cfg_step;
	logic [SIZE_W-1:0] slot_link [DEPTH];
	logic [VER_W-1:0]  slot_gen [DEPTH];
	logic              slot_freed [DEPTH];
	logic [SIZE_W-1:0] free_head, active_size;

	pool_result_t pool_results_due [$];

	function automatic logic [SIZE_W-1:0] cap_depth(input logic [CFG_W-1:0] v);
		return (v > LINK_END) ? LINK_END : v;
	endfunction

	function automatic void chain_slots(input int from, input int to);
		for (int i = from; i < to; i++) begin
			slot_link[i] = (i + 1 < to) ? SIZE_W'(i + 1) : LINK_END;
			slot_gen[i] = '0;
			slot_freed[i] = 1'b0;
		end
	endfunction

	function automatic void rebuild_pool();
		active_size = cap_depth(cfg_initial);
		chain_slots(0, int'(active_size));
		free_head = (active_size != 0) ? '0 : LINK_END;
	endfunction

	function automatic void grow_pool();
		logic [SIZE_W-1:0] lim, old_size, new_size;
		logic [SIZE_W:0]   sum;
		lim = cap_depth(cfg_max);
		old_size = active_size;
		if (old_size >= lim || cfg_step == 0) return;
		sum = {1'b0, old_size} + {1'b0, cfg_step};
		new_size = (sum > {1'b0, lim}) ? lim : sum[SIZE_W-1:0];
		chain_slots(int'(old_size), int'(new_size));
		active_size = new_size;
		if (free_head == LINK_END) free_head = old_size;
		else slot_link[free_head] = old_size;
		n_grows++;
	endfunction

	function automatic logic handle_live(input logic [IDX_W-1:0] idx, input logic [VER_W-1:0] ver);
		if ({1'b0, idx} >= active_size || ver == 0) return 1'b0;
		return !slot_freed[idx] && slot_gen[idx] == ver;
	endfunction

	function automatic pool_result_t pool_apply(input op_t o, input logic [IDX_W-1:0] idx,
			input logic [VER_W-1:0] ver);
		pool_result_t res;
		logic [SIZE_W-1:0] h;
		logic [VER_W-1:0]  m;
		res = '0;
		res.status = ST_OK;
		case (o)
			OP_ALLOC: begin
				if (free_head == LINK_END) grow_pool();
				if (free_head == LINK_END) begin
					res.status = ST_EXHAUSTED;
				end else begin
					h = free_head;
					free_head = slot_link[h];
					if (free_head == LINK_END || slot_link[free_head] == LINK_END) grow_pool();
					m = (slot_gen[h] == VER_TOP) ? VER_W'(1) : slot_gen[h] + 1'b1;
					slot_gen[h] = m;
					slot_freed[h] = 1'b0;
					res.slot = h[IDX_W-1:0];
					res.version = m;
				end
			end
			OP_RELEASE: begin
				res.slot = idx;
				if (!handle_live(idx, ver)) begin
					res.status = ST_STALE;
				end else begin
					slot_link[idx] = free_head;
					slot_freed[idx] = 1'b1;
					free_head = {1'b0, idx};
				end
			end
			OP_CHECK: begin
				res.slot = idx;
				if (!handle_live(idx, ver)) res.status = ST_STALE;
			end
			default: begin
				rebuild_pool();
			end
		endcase
		res.size = active_size;
		return res;
	endfunction

	function automatic void pool_reset();
		cfg_initial = RST_INITIAL;
		cfg_max = RST_MAX;
		cfg_step = RST_STEP;
		for (int i = 0; i < DEPTH; i++) begin
			slot_link[i] = LINK_END;
			slot_gen[i] = '0;
			slot_freed[i] = 1'b0;
		end
		rebuild_pool();
	endfunction

	function automatic void compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: mismatch on %s: expected %0d actual %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pool_result_t want;
		if (!arst_n) begin
			pool_reset();
			pool_results_due.delete();
			fail_count = 0;
			n_results = 0;
			n_exhausted = 0;
			n_stale = 0;
			n_grows = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_INITIAL: cfg_initial = cfg_data;
					CFG_MAX:     cfg_max = cfg_data;
					CFG_STEP:    cfg_step = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pool_results_due.size() == 0) begin
					$display("%0t: result with none expected: status %0d slot %0d version %0d size %0d",
						$time, status, slot_out, version_out, pool_size);
					fail_count++;
				end else begin
					want = pool_results_due.pop_front();
					compare_field("status", want.status, status);
					compare_field("slot_out", want.slot, slot_out);
					compare_field("version_out", want.version, version_out);
					compare_field("pool_size", want.size, pool_size);
					n_results++;
					if (status == ST_EXHAUSTED) n_exhausted++;
					if (status == ST_STALE) n_stale++;
				end
			end
			if (in_valid && in_ready)
				pool_results_due.push_back(pool_apply(op_t'(op), handle_index, handle_version));
			pending <= pool_results_due.size();
		end
	end

endmodule

### test/tb_top.sv
// tb_top: stimulus for generational_slot_pool_unit with directed handle cases, a single-slot
// cycling pass and random phases under varied idling. Depends on gsp_pkg, the unit and
// gsp_pool_checker, which predicts and compares every result.
module tb_top;
	import gsp_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [VER_W-1:0] ver;
	} pool_handle_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_INITIAL;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [OP_W-1:0]      op = OP_ALLOC;
	logic [IDX_W-1:0]     handle_index = '0;
	logic [VER_W-1:0]     handle_version = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [STAT_W-1:0]    status;
	logic [IDX_W-1:0]     slot_out;
	logic [VER_W-1:0]     version_out;
	logic [SIZE_W-1:0]    pool_size;

	int fail_count, pending, n_results, n_exhausted, n_stale, n_grows;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int n_sent = 0;
	int wrap_allocs = 0;

	op_t          ops_in_flight [$];
	pool_handle_t live_handles [$];
	pool_handle_t freed_handles [$];

	generational_slot_pool_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .handle_index(handle_index), .handle_version(handle_version),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .slot_out(slot_out), .version_out(version_out), .pool_size(pool_size)
	);

	gsp_pool_checker pool_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .handle_index(handle_index), .handle_version(handle_version),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .slot_out(slot_out), .version_out(version_out), .pool_size(pool_size),
		.fail_count(fail_count), .pending(pending), .n_results(n_results),
		.n_exhausted(n_exhausted), .n_stale(n_stale), .n_grows(n_grows)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("generational_slot_pool_unit verification failed");
		$finish;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	// track handles handed out so that requests can carry live ones
	always @(posedge clk) begin
		op_t done_op;
		if (arst_n && out_valid && out_ready && ops_in_flight.size() > 0) begin
			done_op = ops_in_flight.pop_front();
			if (done_op == OP_ALLOC && status == ST_OK)
				live_handles.push_back('{slot_out, version_out});
			else if (done_op == OP_REINIT)
				live_handles.delete();
		end
	end

	task automatic send_request(input op_t o, input logic [IDX_W-1:0] idx,
			input logic [VER_W-1:0] ver);
		int gap;
		gap = 0;
		while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		handle_index <= idx;
		handle_version <= ver;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		ops_in_flight.push_back(o);
		n_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_pool_config(input logic [CFG_W-1:0] init_v, input logic [CFG_W-1:0] max_v,
			input logic [CFG_W-1:0] step_v);
		cfg_we <= 1'b1;
		cfg_index <= CFG_INITIAL;
		cfg_data <= init_v;
		@(posedge clk);
		cfg_index <= CFG_MAX;
		cfg_data <= max_v;
		@(posedge clk);
		cfg_index <= CFG_STEP;
		cfg_data <= step_v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_request();
		int r, k;
		pool_handle_t hd;
		logic [VER_W-1:0] ver;
		r = $urandom_range(99);
		if (r < 40 || (r < 77 && live_handles.size() == 0)) begin
			send_request(OP_ALLOC, IDX_W'($urandom), VER_W'($urandom));
		end else if (r < 62) begin
			k = $urandom_range(live_handles.size() - 1);
			hd = live_handles[k];
			live_handles.delete(k);
			freed_handles.push_back(hd);
			if (freed_handles.size() > 16) void'(freed_handles.pop_front());
			send_request(OP_RELEASE, hd.idx, hd.ver);
		end else if (r < 77) begin
			hd = live_handles[$urandom_range(live_handles.size() - 1)];
			send_request(OP_CHECK, hd.idx, hd.ver);
		end else if (r < 83 && freed_handles.size() > 0) begin
			hd = freed_handles[$urandom_range(freed_handles.size() - 1)];
			send_request($urandom_range(1) ? OP_RELEASE : OP_CHECK, hd.idx, hd.ver);
		end else if (r < 97) begin
			case ($urandom_range(3))
				0: ver = '0;
				1: ver = VER_W'($urandom_range(1, 3));
				default: ver = VER_W'($urandom);
			endcase
			send_request($urandom_range(1) ? OP_RELEASE : OP_CHECK, IDX_W'($urandom), ver);
		end else begin
			send_request(OP_REINIT, IDX_W'($urandom), VER_W'($urandom));
		end
	endtask

	initial begin
		logic [VER_W-1:0] wrap_ver;
		logic [CFG_W-1:0] init_v, max_v, step_v;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset configuration: handle validity cases
		send_request(OP_CHECK, '0, '0);
		send_request(OP_ALLOC, '0, '0);
		send_request(OP_CHECK, '0, VER_W'(1));
		send_request(OP_RELEASE, '0, VER_W'(1));
		send_request(OP_RELEASE, '0, VER_W'(1));
		send_request(OP_CHECK, '0, VER_W'(1));
		send_request(OP_ALLOC, '1, '1);
		send_request(OP_CHECK, '1, '1);
		send_request(OP_RELEASE, IDX_W'(64), VER_W'(1));
		send_request(OP_CHECK, '0, '1);
		send_request(OP_CHECK, '0, VER_W'(2));

		// empty pool that cannot grow
		wait_drained();
		set_pool_config('0, '0, '0);
		send_request(OP_REINIT, '0, '0);
		send_request(OP_ALLOC, '0, '0);
		send_request(OP_CHECK, '0, VER_W'(1));

		// growth from an empty list up to the maximum
		wait_drained();
		set_pool_config('0, CFG_W'(5), CFG_W'(3));
		send_request(OP_REINIT, '0, '0);
		repeat (6) send_request(OP_ALLOC, '0, '0);

		// initial size above the maximum
		wait_drained();
		set_pool_config(CFG_W'(3), CFG_W'(2), CFG_W'(2));
		send_request(OP_REINIT, '0, '0);
		repeat (4) send_request(OP_ALLOC, '0, '0);

		// oversized registers clamp to the pool depth
		wait_drained();
		set_pool_config('1, '1, '1);
		send_request(OP_REINIT, '0, '0);
		send_request(OP_ALLOC, '0, '0);
		send_request(OP_CHECK, '1, '0);

		// one slot allocated and released repeatedly
		wait_drained();
		set_pool_config(CFG_W'(1), CFG_W'(1), CFG_W'(1));
		send_request(OP_REINIT, '0, '0);
		wrap_ver = '0;
		for (int k = 0; k < 8; k++) begin
			wrap_ver = (wrap_ver == '1) ? VER_W'(1) : wrap_ver + 1'b1;
			send_request(OP_ALLOC, '0, '0);
			send_request(OP_RELEASE, '0, wrap_ver);
			wrap_allocs++;
		end
		send_request(OP_ALLOC, '0, '0);

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin init_v = '1; max_v = '1; step_v = '1; end
				1: begin init_v = CFG_W'(1); max_v = CFG_W'(1024); step_v = CFG_W'(1); end
				2: begin init_v = '0; max_v = CFG_W'(3); step_v = '1; end
				5: begin init_v = CFG_W'(1024); max_v = CFG_W'(1024); step_v = CFG_W'(1024); end
				default: begin
					init_v = CFG_W'($urandom_range(0, 16));
					max_v = CFG_W'($urandom_range(0, 48));
					step_v = CFG_W'($urandom_range(0, 12));
				end
			endcase
			case (p % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 77; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 77; end
				default: begin send_idle_pct = 20; stall_pct = 20; end
			endcase
			wait_drained();
			set_pool_config(init_v, max_v, step_v);
			send_request(OP_REINIT, '0, '0);
			for (int i = 0; i < 175; i++) begin
				if ($urandom_range(99) < 2) wait_drained();
				random_request();
			end
		end

		wait_drained();
		repeat (100) @(posedge clk);
		$display("run covered %0d requests, %0d results checked: %0d ok, %0d exhausted, %0d stale",
			n_sent, n_results, n_results - n_exhausted - n_stale, n_exhausted, n_stale);
		$display("pool grew %0d times; one slot cycled through %0d allocate and release pairs",
			n_grows, wrap_allocs);
		if (fail_count == 0 && pending == 0) begin
			$display("generational_slot_pool_unit verification clean");
		end else begin
			$display("generational_slot_pool_unit verification failed");
		end
		$finish;
	end

endmodule
